// ----- src/psin_pkg.sv -----
`default_nettype none

package psin_pkg;

  // Field widths of the stream words
  localparam int unsigned ANGLE_W = 16;
  localparam int unsigned TERMS_W = 7;
  localparam int unsigned OUT_W   = 24;

  localparam int unsigned MAX_TERMS_DEF = 64;

  // Running product Q7.24, scaled angle square Q3.24
  localparam int unsigned P_W    = 32;
  localparam int unsigned FACT_W = 27;
  localparam int unsigned DVD_W  = 28;
  localparam int unsigned TERM_W = 30;

  // Shared multiplier operand and product widths
  localparam int unsigned MUL_W  = 33;
  localparam int unsigned PROD_W = 2 * MUL_W;

  // 1/pi^2 in Q0.32
  localparam logic [28:0] INV_PI_SQ_Q32 = 29'd435171170;
  localparam logic [DVD_W-1:0] ONE_Q24  = DVD_W'(1) << 24;

endpackage

`default_nettype wire

// ----- src/psin_mul.sv -----
`default_nettype none

module psin_mul (
  input  logic                                 clk_i,
  input  logic signed [psin_pkg::MUL_W-1:0]    op_a_i,
  input  logic signed [psin_pkg::MUL_W-1:0]    op_b_i,
  output logic signed [psin_pkg::PROD_W-1:0]   prod_o
);
  import psin_pkg::*;

  logic signed [PROD_W-1:0] prod_q;

  // Register every product; the sequencer picks it up in the next state
  always_ff @(posedge clk_i) begin
    prod_q <= PROD_W'(op_a_i) * PROD_W'(op_b_i);
  end

  assign prod_o = prod_q;

endmodule

`default_nettype wire

// ----- src/psin_div.sv -----
`default_nettype none

module psin_div #(
  parameter int unsigned DsrW = 14
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [psin_pkg::DVD_W-1:0]    dividend_i,
  input  logic [DsrW-1:0]               divisor_i,
  output logic [psin_pkg::DVD_W-1:0]    quotient_o,
  output logic                          busy_o,
  output logic                          done_o
);
  import psin_pkg::*;

  localparam int unsigned CntW = $clog2(DVD_W + 1);

  logic [DVD_W-1:0] dvd_q, dvd_d;
  logic [DsrW-1:0]  rem_q, rem_d;
  logic [DsrW-1:0]  dsr_q, dsr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             done_q, done_d;
  logic [DsrW:0]    rem_sh;
  logic [DsrW:0]    diff;
  logic             fits;

  // Restoring division, one quotient bit per cycle
  assign rem_sh = {rem_q, dvd_q[DVD_W-1]};
  assign diff   = rem_sh - {1'b0, dsr_q};
  assign fits   = (rem_sh >= {1'b0, dsr_q});

  always_comb begin
    dvd_d  = dvd_q;
    rem_d  = rem_q;
    dsr_d  = dsr_q;
    cnt_d  = cnt_q;
    done_d = 1'b0;
    if (start_i) begin
      dvd_d = dividend_i;
      rem_d = '0;
      dsr_d = divisor_i;
      cnt_d = CntW'(DVD_W);
    end else if (cnt_q != '0) begin
      rem_d  = fits ? diff[DsrW-1:0] : rem_sh[DsrW-1:0];
      dvd_d  = {dvd_q[DVD_W-2:0], fits};
      cnt_d  = cnt_q - 1'b1;
      done_d = (cnt_q == CntW'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    rem_q <= rem_d;
    dsr_q <= dsr_d;
  end

  assign quotient_o = dvd_q;
  assign busy_o     = (cnt_q != '0);
  assign done_o     = done_q;

endmodule

`default_nettype wire

// ----- src/product_series_sine.sv -----
// Each word runs through the sequencer one term at a time, k = min(terms, MaxTerms) terms,
// and every term waits on the serial divider.
// The shared multiplier and the radix-2 divider serve one word at a time,
// and ready is high only while the sequencer idles.
// Reset: asynchronous, active low; clears the sequencer and the output valid flag.
`default_nettype none

module product_series_sine #(
  parameter int unsigned MaxTerms = psin_pkg::MAX_TERMS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [23:0] s_axis_tdata_i,   // [15:0] angle, [22:16] terms, [23] zero
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [23:0] m_axis_tdata_o,   // [23:0] sine_value
  output logic [0:0]  m_axis_tuser_o    // [0] saturated
);
  import psin_pkg::*;

  // Loop counter must reach k + 1 to see the exit
  localparam int unsigned IW    = $clog2(MaxTerms + 2);
  localparam int unsigned DSR_W = 2 * IW;
  localparam int unsigned SH_W  = PROD_W - 24;

  localparam logic signed [P_W-1:0]   P_MAX_C   = {1'b0, {(P_W-1){1'b1}}};
  localparam logic signed [P_W-1:0]   P_MIN_C   = {1'b1, {(P_W-1){1'b0}}};
  localparam logic signed [OUT_W-1:0] OUT_MAX_C = {1'b0, {(OUT_W-1){1'b1}}};
  localparam logic signed [OUT_W-1:0] OUT_MIN_C = {1'b1, {(OUT_W-1){1'b0}}};

  typedef enum logic [8:0] {
    ST_IDLE = 9'b000000001,
    ST_SQ   = 9'b000000010,
    ST_FAC  = 9'b000000100,
    ST_FRD  = 9'b000001000,
    ST_LOOP = 9'b000010000,
    ST_DSQ  = 9'b000100000,
    ST_DIV  = 9'b001000000,
    ST_RND  = 9'b010000000,
    ST_FIN  = 9'b100000000
  } state_e;

  state_e state_q, state_d;

  logic signed [ANGLE_W-1:0] angle_q, angle_d;
  logic [IW-1:0]             k_q, k_d;
  logic [IW-1:0]             i_q, i_d;
  logic [FACT_W-1:0]         factor_q, factor_d;
  logic signed [P_W-1:0]     p_q, p_d;
  logic                      sat_q, sat_d;

  logic                      m_valid_q, m_valid_d;
  logic signed [OUT_W-1:0]   m_data_q, m_data_d;
  logic                      m_sat_q, m_sat_d;
  logic                      out_free;

  logic signed [MUL_W-1:0]   mul_a, mul_b;
  logic signed [PROD_W-1:0]  prod;

  logic                      div_start;
  logic [DVD_W-1:0]          div_dividend;
  logic [DSR_W-1:0]          div_divisor;
  logic [DVD_W-1:0]          div_quot;
  logic                      div_busy;
  logic                      div_done;

  logic signed [TERM_W-1:0]  term;
  logic [61:0]               fac_sum;
  logic signed [PROD_W-1:0]  p_rnd;
  logic signed [SH_W-1:0]    p_sh;
  logic signed [P_W:0]       r_rnd;
  logic signed [P_W-8:0]     r_sh;

  logic [ANGLE_W-1:0]        in_angle;
  logic [TERMS_W-1:0]        in_terms;
  logic                      in_acc;

  assign in_angle = s_axis_tdata_i[ANGLE_W-1:0];
  assign in_terms = s_axis_tdata_i[ANGLE_W+TERMS_W-1:ANGLE_W];

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign in_acc          = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free        = !m_valid_q || m_axis_tready_i;

  // One shared multiplier for alpha^2, the 1/pi^2 scaling, i^2 and the running product
  psin_mul u_mul (
    .clk_i  (clk_i),
    .op_a_i (mul_a),
    .op_b_i (mul_b),
    .prod_o (prod)
  );

  // Serial divider for factor / i^2, rounded by adding i^2/2 to the dividend
  psin_div #(
    .DsrW (DSR_W)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .quotient_o (div_quot),
    .busy_o     (div_busy),
    .done_o     (div_done)
  );

  assign div_start    = (state_q == ST_DSQ);
  assign div_divisor  = prod[DSR_W-1:0];
  assign div_dividend = DVD_W'(factor_q) + DVD_W'(prod[DSR_W-1:1]);

  // term = 1.0 - q, may go negative for large angles
  assign term = $signed({2'b00, ONE_Q24}) - $signed({2'b00, div_quot});

  // Multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      ST_SQ: begin
        mul_a = MUL_W'(angle_q);
        mul_b = MUL_W'(angle_q);
      end
      ST_FAC: begin
        mul_a = $signed({1'b0, prod[P_W-1:0]});
        mul_b = $signed(MUL_W'(INV_PI_SQ_Q32));
      end
      ST_LOOP: begin
        mul_a = $signed(MUL_W'(i_q));
        mul_b = $signed(MUL_W'(i_q));
      end
      ST_DIV: begin
        mul_a = MUL_W'(p_q);
        mul_b = MUL_W'(term);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // factor = round(alpha^2 / pi^2) in Q3.24
  assign fac_sum = prod[61:0] + (62'd1 << 31);

  // Round p * term >> 24 half away from zero
  assign p_rnd = prod[PROD_W-1] ? (prod + PROD_W'(24'h7FFFFF)) : (prod + PROD_W'(24'h800000));
  assign p_sh  = SH_W'(p_rnd >>> 24);

  // Final rounding to Q7.16, half away from zero
  assign r_rnd = p_q[P_W-1] ? ((P_W+1)'(p_q) + (P_W+1)'(127))
                            : ((P_W+1)'(p_q) + (P_W+1)'(128));
  assign r_sh  = (P_W-7)'(r_rnd >>> 8);

  always_comb begin
    state_d   = state_q;
    angle_d   = angle_q;
    k_d       = k_q;
    i_d       = i_q;
    factor_d  = factor_q;
    p_d       = p_q;
    sat_d     = sat_q;
    m_valid_d = m_valid_q;
    m_data_d  = m_data_q;
    m_sat_d   = m_sat_q;

    // Drop valid once the word is taken
    if (m_axis_tready_i) begin
      m_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          angle_d = $signed(in_angle);
          // Clamp the term count at MaxTerms
          k_d     = (32'(in_terms) > 32'(MaxTerms)) ? IW'(MaxTerms) : IW'(in_terms);
          i_d     = IW'(1);
          p_d     = P_W'($signed(in_angle)) <<< 12;
          sat_d   = 1'b0;
          state_d = ST_SQ;
        end
      end
      ST_SQ: begin
        state_d = ST_FAC;
      end
      ST_FAC: begin
        state_d = ST_FRD;
      end
      ST_FRD: begin
        factor_d = fac_sum[32+FACT_W-1:32];
        state_d  = ST_LOOP;
      end
      ST_LOOP: begin
        // Issue i*i here; leave once every term is applied
        state_d = (i_q > k_q) ? ST_FIN : ST_DSQ;
      end
      ST_DSQ: begin
        state_d = ST_DIV;
      end
      ST_DIV: begin
        if (div_done) begin
          state_d = ST_RND;
        end
      end
      ST_RND: begin
        if (p_sh > SH_W'(P_MAX_C)) begin
          p_d   = P_MAX_C;
          sat_d = 1'b1;
        end else if (p_sh < SH_W'(P_MIN_C)) begin
          p_d   = P_MIN_C;
          sat_d = 1'b1;
        end else begin
          p_d = P_W'(p_sh);
        end
        i_d     = i_q + 1'b1;
        state_d = ST_LOOP;
      end
      ST_FIN: begin
        // Hold until the output register is free
        if (out_free) begin
          m_valid_d = 1'b1;
          if (r_sh > (P_W-7)'(OUT_MAX_C)) begin
            m_data_d = OUT_MAX_C;
            m_sat_d  = 1'b1;
          end else if (r_sh < (P_W-7)'(OUT_MIN_C)) begin
            m_data_d = OUT_MIN_C;
            m_sat_d  = 1'b1;
          end else begin
            m_data_d = OUT_W'(r_sh);
            m_sat_d  = sat_q;
          end
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    angle_q  <= angle_d;
    k_q      <= k_d;
    i_q      <= i_d;
    factor_q <= factor_d;
    p_q      <= p_d;
    sat_q    <= sat_d;
    m_data_q <= m_data_d;
    m_sat_q  <= m_sat_d;
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;
  assign m_axis_tuser_o  = m_sat_q;

  // An accepted word always starts the square step
  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> (state_q == ST_SQ))
    else $error("accepted word did not start the sequencer");

  // Finishing with a free output slot presents a result next cycle
  a_fin_presents: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FIN) && out_free |=> m_axis_tvalid_o)
    else $error("finished result not presented");

  // The divider is at work for the whole wait state
  a_div_active: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV) |-> (div_busy || div_done))
    else $error("waiting on an idle divider");

  // The term index never runs past k + 1
  a_index_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_LOOP) |-> ((IW+1)'(i_q) <= (IW+1)'(k_q) + (IW+1)'(1)))
    else $error("term index overran the count");

endmodule

`default_nettype wire

// ----- verif/product_series_sine_tb.sv -----
`timescale 1ns / 100ps

module product_series_sine_tb;
  import psin_pkg::*;

  // Timing of the run
  localparam int unsigned HALF_PERIOD = 5;
  localparam int unsigned RANDOM_WORDS = 370;
  // Room for a word with the full 64 terms; allow for sink stalls on top
  localparam int unsigned DRAIN_CYCLES = 2100;
  localparam longint unsigned CYCLE_LIMIT = 4_000_000;

  // Scaling of the Euler product datapath
  localparam longint unsigned INV_PI_SQ = 64'd435171170;   // 1/pi^2 in Q0.32
  localparam longint signed UNITY_Q24 = 64'sd16777216;
  localparam longint signed RUN_MAX = 64'sd2147483647;
  localparam longint signed RUN_MIN = -64'sd2147483648;
  localparam longint signed SINE_MAX = 64'sd8388607;
  localparam longint signed SINE_MIN = -64'sd8388608;

  typedef logic signed [ANGLE_W-1:0] angle_t;
  typedef logic [TERMS_W-1:0] terms_t;

  typedef struct packed {
    logic [OUT_W-1:0] sine;
    logic             sat;
  } sine_res_t;

  // One row of the directed table; typed = 1 means the expected word is given here
  typedef struct packed {
    angle_t           angle;
    terms_t           terms;
    logic             typed;
    logic [OUT_W-1:0] sine;
    logic             sat;
  } stim_row_t;

  localparam int unsigned N_DIRECTED = 22;
  localparam stim_row_t DIRECTED [N_DIRECTED] = '{
    // zero terms pass the angle through, rescaled from Q4.12 to Q7.16
    '{16'sd0,      7'd0,   1'b1, 24'd0,         1'b0},
    '{16'sd1,      7'd0,   1'b1, 24'd16,        1'b0},
    '{-16'sd1,     7'd0,   1'b1, 24'hFFFFF0,    1'b0},
    '{16'sd32767,  7'd0,   1'b1, 24'd524272,    1'b0},
    '{-16'sd32768, 7'd0,   1'b1, 24'hF80000,    1'b0},
    // zero angle stays zero whatever the term count
    '{16'sd0,      7'd64,  1'b1, 24'd0,         1'b0},
    '{16'sd0,      7'd127, 1'b1, 24'd0,         1'b0},
    // extremes of angle and count, counts past the maximum clamp to it
    '{16'sd32767,  7'd1,   1'b0, 24'd0,         1'b0},
    '{16'sd32767,  7'd64,  1'b0, 24'd0,         1'b0},
    '{16'sd32767,  7'd127, 1'b0, 24'd0,         1'b0},
    '{-16'sd32768, 7'd1,   1'b0, 24'd0,         1'b0},
    '{-16'sd32768, 7'd64,  1'b0, 24'd0,         1'b0},
    '{-16'sd32768, 7'd65,  1'b0, 24'd0,         1'b0},
    '{-16'sd32768, 7'd127, 1'b0, 24'd0,         1'b0},
    '{16'sd1,      7'd127, 1'b0, 24'd0,         1'b0},
    // around the zeros and peaks of sine
    '{16'sd12868,  7'd64,  1'b0, 24'd0,         1'b0},
    '{-16'sd12868, 7'd10,  1'b0, 24'd0,         1'b0},
    '{16'sd6434,   7'd64,  1'b0, 24'd0,         1'b0},
    '{16'sd25736,  7'd8,   1'b0, 24'd0,         1'b0},
    '{16'sd4096,   7'd1,   1'b0, 24'd0,         1'b0},
    '{16'sd4096,   7'd32,  1'b0, 24'd0,         1'b0},
    '{16'sh5555,   7'h55,  1'b0, 24'd0,         1'b0}
  };

  logic             clk_i = 1'b0;
  logic             rst_ni;
  logic             s_axis_tvalid_i;
  logic             s_axis_tready_o;
  logic [23:0]      s_axis_tdata_i;    // [15:0] angle, [22:16] terms, [23] zero
  logic             m_axis_tvalid_o;
  logic             m_axis_tready_i;
  logic [23:0]      m_axis_tdata_o;    // [23:0] sine_value
  logic [0:0]       m_axis_tuser_o;    // [0] saturated

  sine_res_t        pending_sines [$];
  sine_res_t        want;
  int unsigned      sine_errors = 0;
  longint unsigned  cycle_count = 0;
  // Set during the calm stretch: neither side idles
  logic             steady = 1'b0;

  product_series_sine u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  always #HALF_PERIOD clk_i = ~clk_i;

  // Round a right shift to nearest, ties away from zero
  function automatic longint signed half_away(input longint signed x, input int unsigned n);
    longint signed half;
    half = 64'sd1 <<< (n - 1);
    if (x >= 0) return (x + half) >>> n;
    return -((-x + half) >>> n);
  endfunction

  // Truncated Euler product: alpha * prod (1 - alpha^2 / (pi^2 i^2))
  function automatic sine_res_t euler_sine(input angle_t ang, input terms_t trm);
    longint signed   alpha;
    longint signed   run;
    longint signed   factor_term;
    longint signed   rounded;
    longint unsigned sq;
    longint unsigned scaled_sq;
    longint unsigned isq;
    longint unsigned quo;
    int unsigned     k;
    logic            clipped;
    sine_res_t       res;
    alpha = ang;
    clipped = 1'b0;
    k = (trm > MAX_TERMS_DEF) ? MAX_TERMS_DEF : trm;
    sq = $unsigned(alpha * alpha);
    scaled_sq = (sq * INV_PI_SQ + (64'd1 << 31)) >> 32;
    run = alpha * 4096;
    for (int unsigned i = 1; i <= k; i++) begin
      isq = i * i;
      quo = (scaled_sq + isq / 2) / isq;
      factor_term = UNITY_Q24 - $signed(quo);
      run = half_away(run * factor_term, 24);
      if (run > RUN_MAX) begin
        run = RUN_MAX;
        clipped = 1'b1;
      end else if (run < RUN_MIN) begin
        run = RUN_MIN;
        clipped = 1'b1;
      end
    end
    rounded = half_away(run, 8);
    if (rounded > SINE_MAX) begin
      rounded = SINE_MAX;
      clipped = 1'b1;
    end else if (rounded < SINE_MIN) begin
      rounded = SINE_MIN;
      clipped = 1'b1;
    end
    res.sine = rounded[OUT_W-1:0];
    res.sat = clipped;
    return res;
  endfunction

  // Present one word from the falling edge on, hold it until the block takes it.
  // tvalid is only ever assigned once per falling edge, so back-to-back words
  // keep it high without a glitch.
  task automatic send_word(input angle_t ang, input terms_t trm);
    @(negedge clk_i);
    while (!steady && $urandom_range(0, 99) < 33) begin
      s_axis_tvalid_i <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {1'b0, trm, ang};
    do @(posedge clk_i); while (!s_axis_tready_o);
  endtask

  // Drop the taken word, then hold until every expected word has come back
  task automatic drain_results();
    @(negedge clk_i);
    s_axis_tvalid_i <= 1'b0;
    while (pending_sines.size() != 0) @(posedge clk_i);
  endtask

  // Sink side: stall about a third of the cycles, except in the calm stretch
  always @(negedge clk_i) begin
    m_axis_tready_i <= steady || ($urandom_range(0, 99) >= 33);
  end

  // Check every result word against the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (pending_sines.size() == 0) begin
        sine_errors++;
        if (sine_errors <= 10)
          $display("ERROR: unexpected result word sine=%h sat=%b",
                   m_axis_tdata_o, m_axis_tuser_o[0]);
      end else begin
        want = pending_sines.pop_front();
        if (want.sine !== m_axis_tdata_o || want.sat !== m_axis_tuser_o[0]) begin
          sine_errors++;
          if (sine_errors <= 10)
            $display("ERROR: sine exp %h got %h, sat exp %b got %b",
                     want.sine, m_axis_tdata_o, want.sat, m_axis_tuser_o[0]);
        end
      end
    end
  end

  // Guard against a hung block
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin : stimulus
    angle_t ang;
    terms_t trm;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i  = '0;
    m_axis_tready_i = 1'b0;
    rst_ni = 1'b0;
    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed table: typed rows carry their own answer, the rest go through the predictor
    for (int r = 0; r < N_DIRECTED; r++) begin
      send_word(DIRECTED[r].angle, DIRECTED[r].terms);
      if (DIRECTED[r].typed)
        pending_sines.push_back(sine_res_t'{sine: DIRECTED[r].sine, sat: DIRECTED[r].sat});
      else
        pending_sines.push_back(euler_sine(DIRECTED[r].angle, DIRECTED[r].terms));
    end

    for (int n = 0; n < RANDOM_WORDS; n++) begin
      // Calm stretch with no idling on either side
      steady = (n >= 120 && n < 200);

      // Stall the source once until the block has fully drained
      if (n == 250) drain_results();

      case ($urandom_range(0, 9))
        0: ang = 16'sh7FFF - angle_t'($urandom_range(0, 15));
        1: ang = 16'sh8000 + angle_t'($urandom_range(0, 15));
        2: ang = angle_t'($urandom_range(0, 63)) - 16'sd32;
        default: ang = angle_t'($urandom_range(0, 65535));
      endcase

      // Keep most counts short, as each term costs a pass through the serial divider
      case ($urandom_range(0, 19))
        0, 1: trm = terms_t'($urandom_range(65, 127));
        2, 3, 4: trm = terms_t'($urandom_range(13, 64));
        default: trm = terms_t'($urandom_range(0, 12));
      endcase

      send_word(ang, trm);
      pending_sines.push_back(euler_sine(ang, trm));
    end

    @(negedge clk_i);
    s_axis_tvalid_i <= 1'b0;
    steady = 1'b0;

    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (sine_errors == 0 && pending_sines.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
src/psin_pkg.sv
src/psin_mul.sv
src/psin_div.sv
src/product_series_sine.sv
verif/product_series_sine_tb.sv
